### hdl/kle_pkg.sv
// Shared types, operation codes and status codes for the keyed list engine.
`timescale 1ns / 1ps
`default_nettype none

package kle_pkg;

    // Default number of entries the list can hold.
    localparam int CAPACITY_DEF = 16;

    // Operation codes carried in the mode field of an input beat.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes carried in a result beat.
    localparam logic [1:0] STS_DONE = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_key;
        logic [31:0]        found_payload;
        logic [4:0]         entry_total;
    } t_out_beat;

    // One stored list entry.
    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        payload;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch a new input beat and clear the scan flags
        logic rd_next;   // read the next entry of the scan
        logic commit;    // final write and count update of the operation
        logic load_out;  // load the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done; // every entry the operation needs has been read
    } t_sts;

endpackage

`default_nettype wire

### hdl/keyed_list_engine.sv
// Top level of the keyed list engine: a bounded list of keyed entries.
`timescale 1ns / 1ps
`default_nettype none

// The engine holds up to CAPACITY (key, payload) entries in list order and
// takes one operation per input beat: insert, remove by key, search by key,
// or clear. The keep_sorted configuration bit, written through i_cfg_we and
// i_cfg_data, selects the list discipline; the user must write it only
// while the engine is idle, and the block itself does not enforce this.
// With the bit clear an insert appends at the tail and a lookup stops at
// the first equal key. With the bit set an insert goes in front of the
// first entry whose key is greater than or equal to the new key, and a
// lookup stops at the first such entry, reporting a hit only if its key is
// equal. Keys compare as signed numbers. Every operation returns exactly one
// result beat with a status, the key and payload of a removed or found
// entry (zero otherwise), and the entry count after the operation. An
// operation makes a single forward pass over the N entries held (N is zero
// for clear and for an insert into a full list), one registered read per
// cycle, with the shift that an insert or a remove needs folded into the
// same pass as a one-entry ripple. The last read then settles, the final
// write and count update follow, the result is loaded into the output
// register once that register is free, and the engine returns to idle
// before it accepts the next beat. The engine takes one operation at a
// time; a finished result waits in an output register, so the next beat
// may be accepted before the result is taken.
module keyed_list_engine #(
    parameter int CAPACITY = kle_pkg::CAPACITY_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  kle_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output kle_pkg::t_out_beat  o_out_beat
);
    import kle_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences capture, scan, commit and result hand-off.
    kle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath owns the entry memory, the count, the configuration bit
    // and the result register.
    kle_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_beat  (i_in_beat),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_beat (o_out_beat)
    );

endmodule

`default_nettype wire

### hdl/kle_ctrl.sv
// Controller state machine of the keyed list engine.
`timescale 1ns / 1ps
`default_nettype none

module kle_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  kle_pkg::t_sts   i_sts,
    output kle_pkg::t_cmd   o_cmd
);
    import kle_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/kle_dpath.sv
// Datapath of the keyed list engine: entry memory, scan pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module kle_dpath #(
    parameter int CAPACITY = kle_pkg::CAPACITY_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_data,
    input  kle_pkg::t_in_beat   i_in_beat,
    input  kle_pkg::t_cmd       i_cmd,
    output kle_pkg::t_sts       o_sts,
    output kle_pkg::t_out_beat  o_out_beat
);
    import kle_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    // Entry memory: one write and one registered read per cycle.
    t_entry             r_mem [CAPACITY];
    t_entry             r_rd_data;
    logic               r_elem_vld;
    logic [IDX_W-1:0]   r_elem_idx;
    logic [CNT_W-1:0]   r_rd_idx;

    logic               r_sorted;
    logic [CNT_W-1:0]   r_count;

    logic [1:0]         r_op;
    t_entry             r_new;
    logic               r_full;
    logic               r_placed;
    logic               r_stop;
    logic               r_found;
    t_entry             r_carry;
    t_entry             r_hit;
    t_out_beat          r_out;

    logic               key_ge;
    logic               key_eq;
    logic               is_lookup;
    logic [CNT_W-1:0]   scan_len;
    logic [CNT_W-1:0]   cnt_after;
    logic [CNT_W+4:0]   total_ext;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    t_out_beat          result;

    assign key_ge    = $signed(r_rd_data.key) >= $signed(r_new.key);
    assign key_eq    = (r_rd_data.key == r_new.key);
    assign is_lookup = (r_op == OP_REMOVE) || (r_op == OP_SEARCH);

    assign scan_len      = ((r_op == OP_CLEAR) || r_full) ? '0 : r_count;
    assign o_sts.scan_done = (r_rd_idx == scan_len);

    always_comb begin
        cnt_after = r_count;
        if ((r_op == OP_INSERT) && !r_full) begin
            cnt_after = r_count + 1'b1;
        end else if ((r_op == OP_REMOVE) && r_found) begin
            cnt_after = r_count - 1'b1;
        end else if (r_op == OP_CLEAR) begin
            cnt_after = '0;
        end
    end

    // Memory write: the final write of an insert, the new entry at its sorted place,
    // or a step of an insert ripple (carry moves up) or remove ripple (entries move down).
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_elem_idx;
        wr_data = r_carry;
        if (i_cmd.commit) begin
            if ((r_op == OP_INSERT) && !r_full) begin
                wr_en   = 1'b1;
                wr_addr = r_count[IDX_W-1:0];
                wr_data = r_placed ? r_carry : r_new;
            end
        end else if (r_elem_vld) begin
            if (r_op == OP_INSERT) begin
                if (r_placed) begin
                    wr_en = 1'b1;
                end else if (r_sorted && key_ge) begin
                    wr_en   = 1'b1;
                    wr_data = r_new;
                end
            end else if ((r_op == OP_REMOVE) && r_stop && r_found) begin
                wr_en   = 1'b1;
                wr_addr = r_elem_idx - 1'b1;
                wr_data = r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_next) begin
            r_rd_data  <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_elem_idx <= r_rd_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sorted   <= 1'b0;
            r_count    <= '0;
            r_elem_vld <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sorted <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_count <= cnt_after;
            end
            r_elem_vld <= i_cmd.rd_next;
            if (i_cmd.capture) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Operation latch and scan flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op          <= i_in_beat.mode;
            r_new.key     <= i_in_beat.key;
            r_new.payload <= i_in_beat.payload;
            r_full        <= (i_in_beat.mode == OP_INSERT) && (r_count == CNT_CAP);
            r_placed      <= 1'b0;
            r_stop        <= 1'b0;
            r_found       <= 1'b0;
        end else if (r_elem_vld) begin
            if (r_op == OP_INSERT) begin
                if (r_placed || (r_sorted && key_ge)) begin
                    r_placed <= 1'b1;
                    r_carry  <= r_rd_data;
                end
            end else if (is_lookup && !r_stop) begin
                if (r_sorted ? key_ge : key_eq) begin
                    r_stop <= 1'b1;
                    if (key_eq) begin
                        r_found <= 1'b1;
                        r_hit   <= r_rd_data;
                    end
                end
            end
        end
    end

    // Once the count is committed, r_count already holds the final value.
    assign total_ext = {5'b0, (i_cmd.commit ? cnt_after : r_count)};

    always_comb begin
        result.status        = STS_DONE;
        result.found_key     = '0;
        result.found_payload = '0;
        result.entry_total   = total_ext[4:0];
        if (r_op == OP_INSERT) begin
            result.status = r_full ? STS_FULL : STS_DONE;
        end else if (is_lookup) begin
            if (r_found) begin
                result.found_key     = r_hit.key;
                result.found_payload = r_hit.payload;
            end else begin
                result.status = STS_MISS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= result;
        end
    end

    assign o_out_beat = r_out;

endmodule

`default_nettype wire
